// ===== rtl/tdpt_pkg.sv =====
// types shared by the trial division prime test controller and datapath
`timescale 1ns / 1ps

package tdpt_pkg;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
    } t_dp_cmd;

    typedef struct packed {
        logic early;
        logic early_val;
        logic sq_gt;
        logic div_done;
        logic rem_zero;
    } t_dp_status;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

// ===== rtl/tdpt_dp.sv =====
// datapath: operand, odd divisor with running square, bit-serial remainder
`timescale 1ns / 1ps

module tdpt_dp
    import tdpt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_n,   n_n;
    logic [W-1:0]  r_d,   n_d;
    logic [W:0]    r_sq,  n_sq;
    logic [W-1:0]  r_sh,  n_sh;
    logic [W-1:0]  r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [W:0]    trial;
    logic          neg, lt2, lt4;

    assign trial = {r_rem, r_sh[W-1]};
    assign neg   = r_n[W-1];
    assign lt2   = (r_n < W'(2));
    assign lt4   = (r_n < W'(4));

    assign o_status.early     = neg | lt4 | ~r_n[0];
    assign o_status.early_val = ~neg & ~lt2 & lt4;
    assign o_status.sq_gt     = (r_sq > {1'b0, r_n});
    assign o_status.div_done  = (r_cnt == CW'(W));
    assign o_status.rem_zero  = (r_rem == '0);

    always_comb begin
        n_n   = r_n;
        n_d   = r_d;
        n_sq  = r_sq;
        n_sh  = r_sh;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_n  = i_value;
            n_d  = W'(3);
            n_sq = (W+1)'(9);
        end
        if (i_cmd.next_div) begin
            n_d  = r_d + W'(2);
            n_sq = r_sq + (W+1)'({r_d, 2'b00}) + (W+1)'(4);
        end
        if (i_cmd.div_start) begin
            n_sh  = r_n;
            n_rem = '0;
            n_cnt = '0;
        end
        if (i_cmd.div_step) begin
            n_sh  = {r_sh[W-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
            if (trial >= {1'b0, r_d}) begin
                n_rem = W'(trial - {1'b0, r_d});
            end else begin
                n_rem = trial[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_d   <= n_d;
        r_sq  <= n_sq;
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

endmodule

// ===== rtl/tdpt_ctrl.sv =====
// controller: input and output handshakes, divisor loop sequencing, result register
`timescale 1ns / 1ps

module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_prime,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state, n_state;
    logic   r_res, n_res;
    logic   r_out_valid, n_out_valid;
    logic   r_out, n_out;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.early) begin
                    n_res   = i_status.early_val;
                    n_state = S_FINISH;
                end else if (i_status.sq_gt) begin
                    n_res   = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (i_status.rem_zero) begin
                    n_res   = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// Trial division prime test, one item at a time.
// Odd divisors d = 3, 5, ... are tried while d*d <= value, one bit-serial remainder of
// DATA_WIDTH steps per divisor; negative, even and values below 4 finish without division.
// A new transfer is taken once the previous result moves to the output register.
// Reset: synchronous, active low, clears the controller state and the output valid.
`timescale 1ns / 1ps

module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_is_prime
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_is_prime (o_is_prime),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    tdpt_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_value  (i_value),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

// ===== rtl/tdpt_chk.sv =====
// port checker for the trial division prime test, bound to the top level
`timescale 1ns / 1ps

module tdpt_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_is_prime
);

    logic [1:0] r_pend, n_pend;
    logic       in_xfer, out_xfer;

    assign in_xfer  = i_valid & o_ready;
    assign out_xfer = o_valid & i_ready;

    always_comb begin
        n_pend = r_pend;
        if (in_xfer && !out_xfer) begin
            n_pend = r_pend + 2'd1;
        end else if (!in_xfer && out_xfer) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_is_prime))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pend != 2'd0)
        else $error("result without a pending input");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two items in flight");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_pend == 2'd0 || (r_pend == 2'd1 && o_valid))
        else $error("ready while an item is in work");

endmodule

bind trial_division_prime_test tdpt_chk u_chk (.*);
